// File: rtl/periodic_timer_table_assert.svh
// Assertion macros used by the timer table RTL.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ptt_pkg.sv
// Types and constants of the periodic timer table.
`default_nettype none

package ptt_pkg;

  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned COUNT_W = 7;

  localparam int unsigned IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned FIRE_W = $clog2(MAX_RESULTS + 1);

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [TIME_W:0]    time_ext_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FIRE_W-1:0]  fire_cnt_t;

  localparam time_t TIME_MAX = '1;
  localparam id_t   ID_MAX   = '1;
  localparam id_t   ID_FIRST = id_t'(1);

  typedef enum logic [1:0] {
    REQ_ONE_SHOT = 2'd0,
    REQ_PERIODIC = 2'd1,
    REQ_CANCEL   = 2'd2,
    REQ_PUMP     = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    RSP_SCHED      = 2'd0,
    RSP_CANCEL     = 2'd1,
    RSP_FIRED      = 2'd2,
    RSP_NONE_FIRED = 2'd3
  } rsp_kind_e;

  typedef struct packed {
    req_kind_e req_type;
    time_t     now_time;
    delay_t    delay_ticks;
    tag_t      event_tag;
    id_t       cancel_id;
  } req_t;

  typedef struct packed {
    rsp_kind_e resp_kind;
    id_t       timer_id;
    tag_t      fired_tag;
    logic      found;
    count_t    pending_count;
    logic      last;
  } rsp_t;

  typedef struct packed {
    id_t    id;
    time_t  due;
    delay_t period;
    tag_t   tag;
  } slot_t;

  // Fired result held back until the walk knows whether it is the final one.
  typedef struct packed {
    id_t  id;
    tag_t tag;
    cnt_t count;
  } pend_t;

endpackage

`default_nettype wire

// File: rtl/periodic_timer_table.sv
// Top level of the periodic timer table: sequencer, slot table and result register.
//
// Usage. Requests arrive on req_i with req_valid_i and are taken at a clock edge where
// req_valid_i is high and req_stall_o is low. Results leave on rsp_o with rsp_valid_o and
// are taken when rsp_stall_i is low. A schedule or cancel transaction gives one result;
// a pump gives one result per fired timer (up to sixteen) or a single "none fired" result,
// and the final result of every request carries last.
// Sequence. A schedule appends the entry (unless rejected) and answers. A cancel walks the
// table one slot a cycle; on a hit it compacts the table over the removed entry and then
// answers. A pump walks the table one slot a cycle unless held by a stalled result, a
// reschedule or a compaction; it reschedules each periodic entry it fires through the shared
// adder, removes each fired one-shot by table compaction, and closes the walk with the final
// result.
// Throughput. One request at a time; req_stall_o is high from acceptance until the last
// result has been loaded into the output register. The next request can then be accepted
// while that result still waits to be taken.
// Stall. A stalled result is held in the output register; the sequencer waits until it is
// taken before loading the next one, so nothing is lost.
// Reset. Asynchronous, active low: the table empties, ids restart at 1, no result is valid.
// Slot contents are not cleared; only occupied slots are ever read.
`default_nettype none

`include "periodic_timer_table_assert.svh"

module periodic_timer_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output      logic          req_stall_o,
  input  wire ptt_pkg::req_t req_i,
  output      logic          rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output      ptt_pkg::rsp_t rsp_o
);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,  // waiting for a request
    S_SCHED = 9'b000000010,  // append entry unless rejected, answer
    S_CSCAN = 9'b000000100,  // cancel: search by id
    S_SHIFT = 9'b000001000,  // compact the table over a removed slot
    S_CDONE = 9'b000010000,  // cancel: answer a hit
    S_PSCAN = 9'b000100000,  // pump: walk slots in order
    S_PER1  = 9'b001000000,  // pump: due + period
    S_PER2  = 9'b010000000,  // pump: catch-up check, write new due
    S_PFIN  = 9'b100000000   // pump: final result
  } state_e;

  state_e             state_q, state_d;
  ptt_pkg::req_t      req_q, req_d;
  ptt_pkg::cnt_t      idx_q, idx_d;       // scan position
  ptt_pkg::cnt_t      sh_q, sh_d;         // compaction position
  ptt_pkg::cnt_t      used_q, used_d;
  ptt_pkg::id_t       next_id_q, next_id_d;
  ptt_pkg::fire_cnt_t n_q, n_d;           // fired results in this pump
  ptt_pkg::pend_t     pend_q, pend_d;
  logic               pend_valid_q, pend_valid_d;
  logic               ret_pump_q, ret_pump_d;
  ptt_pkg::time_t     sum_q, sum_d;

  // Slot table: one read port, one write port.
  ptt_pkg::slot_t     slot_q [ptt_pkg::TIMER_SLOTS];
  ptt_pkg::idx_t      rd_addr;
  ptt_pkg::slot_t     rd;
  logic               wr_en;
  ptt_pkg::idx_t      wr_addr;
  ptt_pkg::slot_t     wr_data;

  // Output register.
  logic               out_valid_q;
  ptt_pkg::rsp_t      out_q;
  logic               out_free;
  logic               emit;
  ptt_pkg::rsp_t      emit_data;

  // Shared saturating adder and time comparator.
  ptt_pkg::time_t     add_a;
  ptt_pkg::delay_t    add_b;
  ptt_pkg::time_ext_t add_raw;
  ptt_pkg::time_t     add_sat;
  ptt_pkg::time_t     cmp_lhs;
  logic               cmp_le;

  ptt_pkg::cnt_t      sh_next;
  logic               shift_more;
  logic               sched_reject;
  logic               is_periodic;

  assign out_free = !out_valid_q || !rsp_stall_i;
  assign sh_next  = sh_q + ptt_pkg::cnt_t'(1);
  assign shift_more = (sh_next < used_q);

  // Read the successor during compaction, the scan slot otherwise.
  assign rd_addr = (state_q == S_SHIFT) ? sh_next[ptt_pkg::IDX_W-1:0]
                                        : idx_q[ptt_pkg::IDX_W-1:0];
  assign rd      = slot_q[rd_addr];

  // Adder operands: now + delay on schedule, now + period in the catch-up step,
  // due + period otherwise.
  assign add_a   = (state_q == S_SCHED || state_q == S_PER2) ? req_q.now_time : rd.due;
  assign add_b   = (state_q == S_SCHED) ? req_q.delay_ticks : rd.period;
  assign add_raw = {1'b0, add_a}
                 + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::DELAY_W){1'b0}}, add_b};
  assign add_sat = add_raw[ptt_pkg::TIME_W] ? ptt_pkg::TIME_MAX
                                            : add_raw[ptt_pkg::TIME_W-1:0];

  assign cmp_lhs = (state_q == S_PER2) ? sum_q : rd.due;
  assign cmp_le  = (cmp_lhs <= req_q.now_time);

  assign is_periodic  = (req_q.req_type == ptt_pkg::REQ_PERIODIC);
  assign sched_reject = (req_q.event_tag == '0)
                     || (is_periodic && req_q.delay_ticks == '0)
                     || (used_q >= ptt_pkg::cnt_t'(ptt_pkg::TIMER_SLOTS));

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    idx_d        = idx_q;
    sh_d         = sh_q;
    used_d       = used_q;
    next_id_d    = next_id_q;
    n_d          = n_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    ret_pump_d   = ret_pump_q;
    sum_d        = sum_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[ptt_pkg::IDX_W-1:0];
    wr_data      = rd;
    emit         = 1'b0;
    emit_data    = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d        = req_i;
          idx_d        = '0;
          n_d          = '0;
          pend_valid_d = 1'b0;
          case (req_i.req_type)
            ptt_pkg::REQ_ONE_SHOT,
            ptt_pkg::REQ_PERIODIC: state_d = S_SCHED;
            ptt_pkg::REQ_CANCEL:   state_d = S_CSCAN;
            ptt_pkg::REQ_PUMP:     state_d = S_PSCAN;
            default:               state_d = S_IDLE;
          endcase
        end
      end

      S_SCHED: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_data.resp_kind     = ptt_pkg::RSP_SCHED;
          emit_data.last          = 1'b1;
          if (sched_reject) begin
            emit_data.pending_count = ptt_pkg::count_t'(used_q);
          end else begin
            wr_en          = 1'b1;
            wr_addr        = used_q[ptt_pkg::IDX_W-1:0];
            wr_data.id     = next_id_q;
            wr_data.due    = add_sat;
            wr_data.period = is_periodic ? req_q.delay_ticks : '0;
            wr_data.tag    = req_q.event_tag;
            used_d         = used_q + ptt_pkg::cnt_t'(1);
            next_id_d      = (next_id_q == ptt_pkg::ID_MAX) ? ptt_pkg::ID_FIRST
                                                            : next_id_q + ptt_pkg::ID_FIRST;
            emit_data.timer_id      = next_id_q;
            emit_data.found         = 1'b1;
            emit_data.pending_count = ptt_pkg::count_t'(used_d);
          end
          state_d = S_IDLE;
        end
      end

      S_CSCAN: begin
        if (idx_q >= used_q) begin
          // Miss: answer with id 0.
          if (out_free) begin
            emit                    = 1'b1;
            emit_data.resp_kind     = ptt_pkg::RSP_CANCEL;
            emit_data.pending_count = ptt_pkg::count_t'(used_q);
            emit_data.last          = 1'b1;
            state_d                 = S_IDLE;
          end
        end else if (req_q.cancel_id != '0 && rd.id == req_q.cancel_id) begin
          sh_d       = idx_q;
          ret_pump_d = 1'b0;
          state_d    = S_SHIFT;
        end else begin
          idx_d = idx_q + ptt_pkg::cnt_t'(1);
        end
      end

      S_SHIFT: begin
        if (shift_more) begin
          wr_en   = 1'b1;
          wr_addr = sh_q[ptt_pkg::IDX_W-1:0];
          wr_data = rd;
          sh_d    = sh_next;
        end else begin
          used_d  = used_q - ptt_pkg::cnt_t'(1);
          state_d = ret_pump_q ? S_PSCAN : S_CDONE;
        end
      end

      S_CDONE: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_data.resp_kind     = ptt_pkg::RSP_CANCEL;
          emit_data.timer_id      = req_q.cancel_id;
          emit_data.found         = 1'b1;
          emit_data.pending_count = ptt_pkg::count_t'(used_q);
          emit_data.last          = 1'b1;
          state_d                 = S_IDLE;
        end
      end

      S_PSCAN: begin
        if (idx_q >= used_q || n_q == ptt_pkg::fire_cnt_t'(ptt_pkg::MAX_RESULTS)) begin
          state_d = S_PFIN;
        end else if (cmp_le) begin
          // Due: release the previous fired result first, then hold this one.
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              emit                    = 1'b1;
              emit_data.resp_kind     = ptt_pkg::RSP_FIRED;
              emit_data.timer_id      = pend_q.id;
              emit_data.fired_tag     = pend_q.tag;
              emit_data.pending_count = ptt_pkg::count_t'(pend_q.count);
            end
            pend_valid_d = 1'b1;
            pend_d.id    = rd.id;
            pend_d.tag   = rd.tag;
            n_d          = n_q + ptt_pkg::fire_cnt_t'(1);
            if (rd.period != '0) begin
              pend_d.count = used_q;
              state_d      = S_PER1;
            end else begin
              pend_d.count = used_q - ptt_pkg::cnt_t'(1);
              sh_d         = idx_q;
              ret_pump_d   = 1'b1;
              state_d      = S_SHIFT;
            end
          end
        end else begin
          idx_d = idx_q + ptt_pkg::cnt_t'(1);
        end
      end

      S_PER1: begin
        sum_d   = add_sat;
        state_d = S_PER2;
      end

      S_PER2: begin
        // No catch-up: if one period is not enough, restart from now.
        wr_en       = 1'b1;
        wr_data.due = cmp_le ? add_sat : sum_q;
        idx_d       = idx_q + ptt_pkg::cnt_t'(1);
        state_d     = S_PSCAN;
      end

      S_PFIN: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (pend_valid_q) begin
            emit_data.resp_kind     = ptt_pkg::RSP_FIRED;
            emit_data.timer_id      = pend_q.id;
            emit_data.fired_tag     = pend_q.tag;
            emit_data.pending_count = ptt_pkg::count_t'(pend_q.count);
          end else begin
            emit_data.resp_kind     = ptt_pkg::RSP_NONE_FIRED;
            emit_data.pending_count = ptt_pkg::count_t'(used_q);
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      next_id_q    <= ptt_pkg::ID_FIRST;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      ret_pump_q   <= 1'b0;
      idx_q        <= '0;
      sh_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      next_id_q    <= next_id_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      ret_pump_q   <= ret_pump_d;
      idx_q        <= idx_d;
      sh_q         <= sh_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    sum_q  <= sum_d;
    if (emit) begin
      out_q <= emit_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_addr] <= wr_data;
    end
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  // Checks on the sequencer and table bookkeeping.
  `PTT_ASSERT_IMP(a_used_bound, clk_i, rst_ni, 1'b1,
    used_q <= ptt_pkg::cnt_t'(ptt_pkg::TIMER_SLOTS), "table count beyond capacity")
  `PTT_ASSERT_IMP(a_id_nonzero, clk_i, rst_ni, 1'b1,
    next_id_q != '0, "id zero about to be handed out")
  `PTT_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, emit,
    !out_valid_q || !rsp_stall_i, "result overwritten while stalled")
  `PTT_ASSERT_NEXT(a_shift_drop, clk_i, rst_ni, state_q == S_SHIFT && !shift_more,
    used_q == $past(used_q) - ptt_pkg::cnt_t'(1), "removal did not shrink the table")

endmodule

`default_nettype wire

// File: bench/periodic_timer_table_tb.sv
// Self-checking bench for the periodic timer table: queued requests, predictor, result check.
module periodic_timer_table_tb;
  import ptt_pkg::*;

  localparam int unsigned RANDOM_REQS = 153;
  localparam int unsigned CALM_TAIL   = 40;    // last requests go out with no idling
  localparam int unsigned DRAIN_WAIT  = 200;   // wait after the drain, sized for a pump over sixteen due one-shots
  localparam int unsigned QUIET_LIMIT = 3000;  // cycles with no transaction on either side
  localparam int unsigned MAX_SHOWN   = 10;

  // Shadow of the timer table: slot contents, occupancy and the next id to hand out.
  typedef struct packed {
    slot_t [TIMER_SLOTS-1:0] slot;
    count_t                  used;
    id_t                     next_id;
  } table_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  req_t req_i       = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  rsp_t rsp_o;

  req_t        send_q[$];     // requests still to be offered
  rsp_t        awaited_q[$];  // predicted results, oldest first
  table_t      model;         // table as the block should hold it, advanced on acceptance
  table_t      plan;          // table as the stimulus expects it, used to pick live ids
  logic        req_took = 1'b0;
  logic        calm = 1'b0;
  int unsigned send_hold = 0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;
  int unsigned fault_count = 0;

  periodic_timer_table DUT (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_stall_o,
    .req_i,
    .rsp_valid_o,
    .rsp_stall_i,
    .rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Saturating add at the top of the time range.
  function automatic time_t time_sum(input time_t a, input time_t b);
    time_ext_t s;
    s = time_ext_t'(a) + time_ext_t'(b);
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Remove one entry and close the gap, keeping insertion order.
  function automatic void drop_slot(inout table_t tbl, input int unsigned idx);
    for (int unsigned j = idx; j + 1 < tbl.used; j++) tbl.slot[j] = tbl.slot[j+1];
    tbl.used--;
  endfunction

  // Apply one request to the table and return the results it gives, in order.
  function automatic int unsigned advance_table(inout table_t tbl, input req_t rq,
                                                output rsp_t [MAX_RESULTS-1:0] res);
    int unsigned n;
    int unsigned i;
    logic        periodic;
    id_t         nid;
    time_t       nxt;
    n   = 0;
    res = '0;
    case (rq.req_type)
      REQ_ONE_SHOT, REQ_PERIODIC: begin
        periodic = (rq.req_type == REQ_PERIODIC);
        res[0].resp_kind = RSP_SCHED;
        // Empty tag, zero period or a full table: reject and keep the id.
        if (rq.event_tag != '0 && !(periodic && rq.delay_ticks == '0) &&
            tbl.used < TIMER_SLOTS) begin
          nid = (tbl.next_id == '0) ? ID_FIRST : tbl.next_id;
          tbl.next_id = (nid == ID_MAX) ? ID_FIRST : nid + ID_FIRST;
          tbl.slot[tbl.used].id     = nid;
          tbl.slot[tbl.used].due    = time_sum(rq.now_time, time_t'(rq.delay_ticks));
          tbl.slot[tbl.used].period = periodic ? rq.delay_ticks : '0;
          tbl.slot[tbl.used].tag    = rq.event_tag;
          tbl.used++;
          res[0].timer_id = nid;
          res[0].found    = 1'b1;
        end
        res[0].pending_count = tbl.used;
        n = 1;
      end
      REQ_CANCEL: begin
        res[0].resp_kind = RSP_CANCEL;
        for (i = 0; i < tbl.used; i++) begin
          if (rq.cancel_id != '0 && tbl.slot[i].id == rq.cancel_id) begin
            drop_slot(tbl, i);
            res[0].timer_id = rq.cancel_id;
            res[0].found    = 1'b1;
            break;
          end
        end
        res[0].pending_count = tbl.used;
        n = 1;
      end
      default: begin
        i = 0;
        while (i < tbl.used && n < MAX_RESULTS) begin
          if (tbl.slot[i].due <= rq.now_time) begin
            res[n].resp_kind = RSP_FIRED;
            res[n].timer_id  = tbl.slot[i].id;
            res[n].fired_tag = tbl.slot[i].tag;
            if (tbl.slot[i].period != '0) begin
              // Advance one period; skip missed periods rather than catch up.
              nxt = time_sum(tbl.slot[i].due, time_t'(tbl.slot[i].period));
              if (nxt <= rq.now_time) nxt = time_sum(rq.now_time, time_t'(tbl.slot[i].period));
              tbl.slot[i].due = nxt;
              i++;
            end else begin
              drop_slot(tbl, i);
            end
            res[n].pending_count = tbl.used;
            n++;
          end else begin
            i++;
          end
        end
        if (n == 0) begin
          res[0].resp_kind     = RSP_NONE_FIRED;
          res[0].pending_count = tbl.used;
          n = 1;
        end
      end
    endcase
    res[n-1].last = 1'b1;
    return n;
  endfunction

  // Queue one request and advance the planning copy so later cancels can aim at live ids.
  task automatic queue_req(input req_kind_e kind, input time_t now, input delay_t dly,
                           input tag_t tg, input id_t cid);
    req_t                   rq;
    rsp_t [MAX_RESULTS-1:0] scratch;
    rq.req_type    = kind;
    rq.now_time    = now;
    rq.delay_ticks = dly;
    rq.event_tag   = tg;
    rq.cancel_id   = cid;
    send_q = {send_q, rq};
    void'(advance_table(plan, rq, scratch));
  endtask

  task automatic note_fault(input string what, input rsp_t want, input rsp_t got);
    fault_count++;
    if (fault_count <= MAX_SHOWN) begin
      $display("%s: expected kind %0d id %0d tag %0d found %0d pending %0d last %0d",
               what, want.resp_kind, want.timer_id, want.fired_tag, want.found,
               want.pending_count, want.last);
      $display("  actual kind %0d id %0d tag %0d found %0d pending %0d last %0d",
               got.resp_kind, got.timer_id, got.fired_tag, got.found,
               got.pending_count, got.last);
    end
  endtask

  // Driver: change request and stall at the falling edge only.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      calm = (send_q.size() < CALM_TAIL);
      // Hold a request until it is accepted, then offer the next or idle.
      if (!req_valid_i || req_took) begin
        if (send_hold != 0) begin
          send_hold--;
          req_valid_i <= 1'b0;
        end else if (send_q.size() != 0) begin
          req_i       <= send_q.pop_front();
          req_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) send_hold = $urandom_range(1, 9);
        end else begin
          req_valid_i <= 1'b0;
        end
      end
      // Stall the result side in bursts, with the stall dropped between them.
      if (stall_left != 0) begin
        stall_left--;
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Monitor: sample both handshakes at the rising edge, check results, predict new ones.
  always @(posedge clk_i) begin
    rsp_t [MAX_RESULTS-1:0] fired;
    rsp_t                   want;
    int unsigned            n;
    logic                   rsp_took;
    if (rst_ni) begin
      req_took = req_valid_i && !req_stall_o;
      rsp_took = rsp_valid_o && !rsp_stall_i;
      if (rsp_took) begin
        if (awaited_q.size() == 0) begin
          note_fault("result with nothing awaited", '0, rsp_o);
        end else begin
          want = awaited_q.pop_front();
          if (want.resp_kind !== rsp_o.resp_kind || want.timer_id !== rsp_o.timer_id ||
              want.fired_tag !== rsp_o.fired_tag || want.found !== rsp_o.found ||
              want.pending_count !== rsp_o.pending_count || want.last !== rsp_o.last)
            note_fault("result mismatch", want, rsp_o);
        end
      end
      // Results of a request never come out at the edge that accepts it.
      if (req_took) begin
        n = advance_table(model, req_i, fired);
        for (int unsigned k = 0; k < n; k++) awaited_q = {awaited_q, fired[k]};
      end
      quiet = (req_took || rsp_took) ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("periodic_timer_table regression: fail");
        $finish;
      end
    end
  end

  initial begin
    req_kind_e   kind;
    time_t       clk_now;
    delay_t      dly;
    tag_t        tg;
    id_t         cid;
    int unsigned pick;
    model         = '0;
    model.next_id = ID_FIRST;
    plan          = model;

    // Directed: empty pump, each rejection, immediate one-shot, missed periods, cancel miss and hit.
    queue_req(REQ_PUMP, '0, '0, '0, '0);
    queue_req(REQ_ONE_SHOT, '0, delay_t'(5), '0, '0);
    queue_req(REQ_PERIODIC, '0, '0, tag_t'(9), '0);
    queue_req(REQ_ONE_SHOT, '0, '0, 16'hFFFF, '0);
    queue_req(REQ_PERIODIC, '0, delay_t'(3), tag_t'(1), '0);
    queue_req(REQ_CANCEL, '0, '0, '0, '0);
    queue_req(REQ_PUMP, '0, '0, '0, '0);
    queue_req(REQ_PUMP, time_t'(100), '0, '0, '0);
    queue_req(REQ_CANCEL, time_t'(100), '0, '0, id_t'(2));
    // Fill the table near the top of time, some dues saturating, then one schedule too many.
    for (int k = 0; k < TIMER_SLOTS + 1; k++)
      queue_req((k % 4 == 3) ? REQ_PERIODIC : REQ_ONE_SHOT, TIME_MAX - time_t'(20),
                (k % 5 == 0) ? 32'hFFFF_FFFF : delay_t'(k),
                (k == 0) ? 16'hFFFF : tag_t'(k), 32'hFFFF_FFFF);
    // Everything is due at the maximum time: a full fire burst with period saturation.
    queue_req(REQ_PUMP, TIME_MAX, 32'hFFFF_FFFF, 16'hFFFF, '0);

    // Random: mostly rising time with small delays so pumps fire, some jumps and wide values.
    clk_now = time_t'(1000);
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if ($urandom_range(0, 19) == 0) clk_now = time_t'({$urandom, $urandom});
      else clk_now = time_sum(clk_now, time_t'($urandom_range(0, 30)));
      case ($urandom_range(0, 7))
        0:       dly = '0;
        1:       dly = delay_t'($urandom);
        default: dly = delay_t'($urandom_range(1, 60));
      endcase
      tg = ($urandom_range(0, 9) == 0) ? '0 : tag_t'($urandom_range(1, 16'hFFFF));
      if (plan.used != 0 && $urandom_range(0, 3) != 0)
        cid = plan.slot[$urandom_range(0, plan.used - 1)].id;
      else
        cid = ($urandom_range(0, 1) != 0) ? id_t'($urandom) :
                                            id_t'($urandom_range(0, plan.next_id));
      pick = $urandom_range(0, 19);
      if (pick < 6)       kind = REQ_ONE_SHOT;
      else if (pick < 9)  kind = REQ_PERIODIC;
      else if (pick < 13) kind = REQ_CANCEL;
      else                kind = REQ_PUMP;
      queue_req(kind, clk_now, dly, tg, cid);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request offered and taken, every predicted result seen.
    do @(negedge clk_i);
    while (send_q.size() != 0 || req_valid_i || awaited_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fault_count == 0 && awaited_q.size() == 0) begin
      $display("periodic_timer_table regression: pass");
    end else begin
      $display("periodic_timer_table regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ptt_pkg.sv
rtl/periodic_timer_table.sv
bench/periodic_timer_table_tb.sv
